// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master register access block.
`default_nettype none
package i2cm_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   typedef enum logic [9:0] {
      PH_IDLE  = 10'b00_0000_0001,
      PH_START = 10'b00_0000_0010,
      PH_SBIT  = 10'b00_0000_0100,
      PH_SACK  = 10'b00_0000_1000,
      PH_GAP   = 10'b00_0001_0000,
      PH_RBIT  = 10'b00_0010_0000,
      PH_RTAIL = 10'b00_0100_0000,
      PH_MACK  = 10'b00_1000_0000,
      PH_NACK  = 10'b01_0000_0000,
      PH_STOP  = 10'b10_0000_0000
   } phase_type;

   typedef enum logic [3:0] {
      ST_DEV  = 4'b0001,
      ST_REG  = 4'b0010,
      ST_DATA = 4'b0100,
      ST_RDEV = 4'b1000
   } stage_type;

   localparam logic [15:0] SLOT_TICKS_RESET = 16'd10;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic [4:0] byte_count;
      logic       sda_in;
   } step_in_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic [7:0] read_data;
      logic       read_valid;
      logic       ack_received;
      logic       busy_res;
      logic       done_res;
   } step_out_type;

endpackage
`default_nettype wire

// ===== rtl/i2cm_if.sv =====
// Channel interfaces: request items, response items and the control register write.
`default_nettype none
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] device_address;
   logic [7:0] register_address;
   logic [7:0] write_data;
   logic [4:0] byte_count;
   logic       sda_in;

   modport source (output valid, action, device_address, register_address, write_data,
                   byte_count, sda_in, input ready);
   modport sink (input valid, action, device_address, register_address, write_data,
                 byte_count, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic [7:0] read_data;
   logic       read_valid;
   logic       ack_received;
   logic       busy_res;
   logic       done_res;

   modport source (output valid, scl_out, sda_out, read_data, read_valid, ack_received,
                   busy_res, done_res, input ready);
   modport sink (input valid, scl_out, sda_out, read_data, read_valid, ack_received,
                 busy_res, done_res, output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/i2cm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module i2cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/i2cm_seq.sv =====
// Slot sequencer: bus phase state, bit shifting and write buffer pointers.
`default_nettype none
module i2cm_seq #(
   parameter int BUFFER_DEPTH = 16,
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
   localparam int PW = $clog2(BUFFER_DEPTH + 1),
   localparam int CW = (PW > 5) ? PW : 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire i2cm_pkg::step_in_type  step_in,
   input  wire logic [15:0]            slot_ticks,
   output i2cm_pkg::step_out_type      step_out,
   output logic                        buf_we,
   output logic [AW-1:0]               buf_waddr,
   output logic [7:0]                  buf_wdata,
   output logic [AW-1:0]               buf_raddr,
   input  wire logic [7:0]             buf_rdata
);
   import i2cm_pkg::*;

   phase_type      phase_ff, phase_in;
   logic [1:0]     step_ff, step_in_nx;
   logic [15:0]    tick_ff, tick_in;
   logic [2:0]     bit_ff, bit_in;
   logic [7:0]     shift_ff, shift_in;
   logic [CW-1:0]  left_ff, left_in;
   logic [PW-1:0]  fill_ff, fill_in;
   logic [PW-1:0]  rptr_ff, rptr_in;
   logic [7:0]     dev_ff, dev_in;
   logic [7:0]     reg_ff, reg_in;
   logic           ack_ff, ack_in;
   logic           scl_ff, scl_in;
   logic           sda_lvl_ff, sda_lvl_in;
   stage_type      stage_ff, stage_in;
   logic           reading_ff, reading_in;

   logic           go_en;
   phase_type      go_ph;
   logic [1:0]     go_st;
   logic [15:0]    len;
   logic [16:0]    tick_sum;
   logic           out_valid;
   logic [7:0]     out_data;
   logic           out_done;
   logic [CW-1:0]  count_w;

   // The buffer is read continuously at the payload pointer; the pointer only
   // moves many items before the next payload fetch, so the data is settled.
   assign buf_raddr = rptr_ff[AW-1:0];
   assign buf_wdata = step_in.write_data;
   assign buf_waddr = fill_ff[AW-1:0];
   assign buf_we    = step_en && (phase_ff == PH_IDLE) && (step_in.action == ACT_LOAD)
                      && (fill_ff < PW'(BUFFER_DEPTH));

   assign len      = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
   assign tick_sum = {1'b0, tick_ff} + 17'd1;
   assign count_w  = CW'(step_in.byte_count);

   always_comb begin
      phase_in   = phase_ff;
      step_in_nx = step_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      fill_in    = fill_ff;
      rptr_in    = rptr_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_lvl_in = sda_lvl_ff;
      stage_in   = stage_ff;
      reading_in = reading_ff;
      go_en      = 1'b0;
      go_ph      = PH_IDLE;
      go_st      = 2'd0;
      out_valid  = 1'b0;
      out_data   = 8'd0;
      out_done   = 1'b0;

      if (phase_ff != PH_IDLE) begin
         tick_in = tick_sum[15:0];
         if (tick_sum >= {1'b0, len}) begin
            tick_in = 16'd0;
            unique case (phase_ff)
               PH_START: begin
                  go_en = 1'b1;
                  if (step_ff < 2'd2) begin
                     go_ph = PH_START;
                     go_st = step_ff + 2'd1;
                  end else begin
                     shift_in = (stage_ff == ST_RDEV) ? dev_ff + 8'd1 : dev_ff;
                     bit_in   = 3'd0;
                     go_ph    = PH_SBIT;
                  end
               end
               PH_SBIT: begin
                  go_en = 1'b1;
                  if (step_ff == 2'd0) begin
                     go_ph = PH_SBIT;
                     go_st = 2'd1;
                  end else if (bit_ff < 3'd7) begin
                     bit_in = bit_ff + 3'd1;
                     go_ph  = PH_SBIT;
                  end else begin
                     go_ph = PH_SACK;
                  end
               end
               PH_SACK: begin
                  go_en = 1'b1;
                  if (step_ff < 2'd2) begin
                     go_ph = PH_SACK;
                     go_st = step_ff + 2'd1;
                  end else begin
                     ack_in = !step_in.sda_in;
                     // Choose what follows the byte just sent.
                     if (stage_ff == ST_DEV) begin
                        stage_in = ST_REG;
                        shift_in = reg_ff;
                        bit_in   = 3'd0;
                        go_ph    = PH_SBIT;
                     end else if (stage_ff == ST_RDEV) begin
                        shift_in = 8'd0;
                        bit_in   = 3'd0;
                        go_ph    = PH_RBIT;
                     end else if (stage_ff == ST_REG && reading_ff) begin
                        go_ph = PH_GAP;
                     end else if (left_ff != '0) begin
                        rptr_in  = rptr_ff + PW'(1);
                        left_in  = left_ff - CW'(1);
                        stage_in = ST_DATA;
                        shift_in = buf_rdata;
                        bit_in   = 3'd0;
                        go_ph    = PH_SBIT;
                     end else begin
                        go_ph = PH_STOP;
                     end
                  end
               end
               PH_GAP: begin
                  go_en = 1'b1;
                  if (step_ff < 2'd2) begin
                     go_ph = PH_GAP;
                     go_st = step_ff + 2'd1;
                  end else begin
                     stage_in = ST_RDEV;
                     go_ph    = PH_START;
                  end
               end
               PH_RBIT: begin
                  go_en = 1'b1;
                  if (step_ff == 2'd0) begin
                     go_ph = PH_RBIT;
                     go_st = 2'd1;
                  end else if (bit_ff < 3'd7) begin
                     bit_in = bit_ff + 3'd1;
                     go_ph  = PH_RBIT;
                  end else begin
                     go_ph = PH_RTAIL;
                  end
               end
               PH_RTAIL: begin
                  go_en = 1'b1;
                  if (left_ff != '0) begin
                     left_in = left_ff - CW'(1);
                  end
                  go_ph = (left_in != '0) ? PH_MACK : PH_NACK;
               end
               PH_MACK: begin
                  go_en = 1'b1;
                  if (step_ff < 2'd2) begin
                     go_ph = PH_MACK;
                     go_st = step_ff + 2'd1;
                  end else begin
                     sda_lvl_in = 1'b1;
                     shift_in   = 8'd0;
                     bit_in     = 3'd0;
                     go_ph      = PH_RBIT;
                  end
               end
               PH_NACK: begin
                  go_en = 1'b1;
                  if (step_ff < 2'd2) begin
                     go_ph = PH_NACK;
                     go_st = step_ff + 2'd1;
                  end else begin
                     go_ph = PH_STOP;
                  end
               end
               PH_STOP: begin
                  if (step_ff < 2'd3) begin
                     go_en = 1'b1;
                     go_ph = PH_STOP;
                     go_st = step_ff + 2'd1;
                  end else begin
                     phase_in   = PH_IDLE;
                     step_in_nx = 2'd0;
                     out_done   = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end else if (step_in.action == ACT_WRITE || step_in.action == ACT_READ) begin
         dev_in     = step_in.device_address;
         reg_in     = step_in.register_address;
         reading_in = (step_in.action == ACT_READ);
         if (reading_in) begin
            left_in = (count_w == '0) ? CW'(1) : count_w;
         end else begin
            left_in = (count_w > CW'(BUFFER_DEPTH)) ? CW'(BUFFER_DEPTH) : count_w;
            fill_in = '0;
         end
         rptr_in  = '0;
         stage_in = ST_DEV;
         bit_in   = 3'd0;
         tick_in  = 16'd0;
         go_en    = 1'b1;
         go_ph    = PH_START;
      end else if (step_in.action == ACT_LOAD) begin
         if (fill_ff < PW'(BUFFER_DEPTH)) begin
            fill_in = fill_ff + PW'(1);
         end
      end

      // Pin changes made on entry to a slot.
      if (go_en) begin
         phase_in   = go_ph;
         step_in_nx = go_st;
         unique case (go_ph)
            PH_START: begin
               if (go_st == 2'd0) begin
                  scl_in     = 1'b1;
                  sda_lvl_in = 1'b1;
               end else if (go_st == 2'd1) begin
                  sda_lvl_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            PH_SBIT: begin
               if (go_st == 2'd0) begin
                  scl_in     = 1'b0;
                  sda_lvl_in = shift_in[3'd7 - bit_in];
               end else begin
                  scl_in = 1'b1;
               end
            end
            PH_SACK: begin
               if (go_st == 2'd0) begin
                  scl_in = 1'b0;
               end else if (go_st == 2'd1) begin
                  sda_lvl_in = 1'b1;
               end else begin
                  scl_in = 1'b1;
               end
            end
            PH_GAP: begin
               if (go_st == 2'd1) begin
                  scl_in = 1'b0;
               end
            end
            PH_RBIT: begin
               if (go_st == 2'd0) begin
                  if (bit_in == 3'd0) begin
                     sda_lvl_in = 1'b1;
                  end
                  scl_in = 1'b0;
               end else begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], step_in.sda_in};
                  if (bit_in == 3'd7) begin
                     out_valid = 1'b1;
                     out_data  = shift_in;
                  end
               end
            end
            PH_RTAIL: begin
               scl_in = 1'b0;
            end
            PH_MACK, PH_NACK: begin
               if (go_st == 2'd0) begin
                  sda_lvl_in = (go_ph == PH_NACK);
               end else if (go_st == 2'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            PH_STOP: begin
               if (go_st == 2'd0) begin
                  scl_in = 1'b0;
               end else if (go_st == 2'd1) begin
                  sda_lvl_in = 1'b0;
               end else if (go_st == 2'd2) begin
                  scl_in = 1'b1;
               end else begin
                  sda_lvl_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      step_out.scl_out      = scl_in;
      step_out.sda_out      = sda_lvl_in;
      step_out.read_data    = out_data;
      step_out.read_valid   = out_valid;
      step_out.ack_received = ack_in;
      step_out.busy_res     = (phase_in != PH_IDLE);
      step_out.done_res     = out_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         step_ff    <= 2'd0;
         tick_ff    <= 16'd0;
         bit_ff     <= 3'd0;
         shift_ff   <= 8'd0;
         left_ff    <= '0;
         fill_ff    <= '0;
         rptr_ff    <= '0;
         dev_ff     <= 8'd0;
         reg_ff     <= 8'd0;
         ack_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_lvl_ff <= 1'b1;
         stage_ff   <= ST_DEV;
         reading_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         step_ff    <= step_in_nx;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         fill_ff    <= fill_in;
         rptr_ff    <= rptr_in;
         dev_ff     <= dev_in;
         reg_ff     <= reg_in;
         ack_ff     <= ack_in;
         scl_ff     <= scl_in;
         sda_lvl_ff <= sda_lvl_in;
         stage_ff   <= stage_in;
         reading_ff <= reading_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/i2c_master_register_access.sv =====
// Top level of the I2C master register access block.
// Latency: each item's result is registered and offered on the cycle after acceptance.
// Throughput: one item per cycle; a new item is taken while the previous result waits,
// as long as the response register is empty or being drained in the same cycle.
// Write buffer bytes live in a registered-read RAM fetched ahead at the payload pointer.
// Synchronous active-high reset returns to idle with both bus lines released, slot 10.
`default_nettype none
module i2c_master_register_access #(
   parameter int BUFFER_DEPTH = 16,
   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
   input wire logic  clock,
   input wire logic  reset,
   i2cm_req_if.sink  req_if,
   i2cm_rsp_if.source rsp_if,
   i2cm_csr_if.sink  csr_if
);
   import i2cm_pkg::*;

   logic          step_en;
   step_in_type   step_in;
   step_out_type  step_out;
   step_out_type  rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   slot_ticks_ff;
   logic          buf_we;
   logic [AW-1:0] buf_waddr;
   logic [7:0]    buf_wdata;
   logic [AW-1:0] buf_raddr;
   logic [7:0]    buf_rdata;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign step_en      = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign step_in.action           = req_if.action;
   assign step_in.device_address   = req_if.device_address;
   assign step_in.register_address = req_if.register_address;
   assign step_in.write_data       = req_if.write_data;
   assign step_in.byte_count       = req_if.byte_count;
   assign step_in.sda_in           = req_if.sda_in;

   i2cm_seq #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .step_in    (step_in),
      .slot_ticks (slot_ticks_ff),
      .step_out   (step_out),
      .buf_we     (buf_we),
      .buf_waddr  (buf_waddr),
      .buf_wdata  (buf_wdata),
      .buf_raddr  (buf_raddr),
      .buf_rdata  (buf_rdata)
   );

   i2cm_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         slot_ticks_ff <= SLOT_TICKS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            slot_ticks_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= step_out;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.scl_out      = rsp_data_ff.scl_out;
   assign rsp_if.sda_out      = rsp_data_ff.sda_out;
   assign rsp_if.read_data    = rsp_data_ff.read_data;
   assign rsp_if.read_valid   = rsp_data_ff.read_valid;
   assign rsp_if.ack_received = rsp_data_ff.ack_received;
   assign rsp_if.busy_res     = rsp_data_ff.busy_res;
   assign rsp_if.done_res     = rsp_data_ff.done_res;
endmodule
`default_nettype wire

// ===== rtl/i2cm_checker.sv =====
// Port-level checks for the I2C master register access block, bound to the top level.
`default_nettype none
module i2cm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_scl_out,
   input wire logic rsp_sda_out,
   input wire logic rsp_read_valid,
   input wire logic rsp_busy_res,
   input wire logic rsp_done_res
);
   // A waiting result is never dropped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The block takes an item whenever the output side can drain.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty response register");

   // A byte can only complete in the middle of a transaction.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_busy_res && !rsp_done_res)
      else $error("read byte outside a transaction");

   // A finished stop leaves the bus released and the block idle.
   a_done_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && rsp_scl_out && rsp_sda_out)
      else $error("transaction end with bus not released");

   // Nothing is offered right after reset, and no item is pending from before it.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind i2c_master_register_access i2cm_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_scl_out    (rsp_if.scl_out),
   .rsp_sda_out    (rsp_if.sda_out),
   .rsp_read_valid (rsp_if.read_valid),
   .rsp_busy_res   (rsp_if.busy_res),
   .rsp_done_res   (rsp_if.done_res)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the I2C master register access block, checked against a slot model.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cm_pkg::*;

   localparam int BUF_DEPTH = 16;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();
   i2cm_csr_if csr_ch ();

   i2c_master_register_access u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #5 clock = ~clock;

   // Bus model state; the initial values are the state after reset.
   phase_type   bus_phase   = PH_IDLE;
   stage_type   xfer_stage  = ST_DEV;
   logic [2:0]  slot_idx    = '0;
   logic [15:0] tick_count  = '0;
   logic [15:0] slot_cfg    = SLOT_TICKS_RESET;
   logic [2:0]  bit_pos     = '0;
   logic [7:0]  shifter     = '0;
   logic [4:0]  bytes_to_go = '0;
   logic [7:0]  tx_buffer [BUF_DEPTH];
   logic [4:0]  tx_fill     = '0;
   logic [4:0]  tx_ptr      = '0;
   logic [7:0]  dev_addr    = '0;
   logic [7:0]  reg_addr    = '0;
   logic        slave_ack   = 1'b0;
   logic        scl_lvl     = 1'b1;
   logic        sda_lvl     = 1'b1;
   logic        is_read     = 1'b0;
   logic        sda_sample;
   logic        got_valid;
   logic        got_done;
   logic [7:0]  got_byte;

   step_out_type expected_steps [$];

   int unsigned mismatch_count  = 0;
   int unsigned items_sent      = 0;
   int unsigned transfers_begun = 0;
   int unsigned transfers_done  = 0;
   int unsigned bytes_read      = 0;
   int unsigned cycle_count     = 0;
   int unsigned drain_cycles    = 0;
   int unsigned gap_percent     = 0;
   int unsigned stall_percent   = 0;
   int unsigned sda_mode        = 2;
   bit          calm            = 1'b0;

   function automatic void enter_slot(input phase_type p, input logic [2:0] st);
      bus_phase = p;
      slot_idx = st;
      case (p)
         PH_START: begin
            if (st == 3'd0) begin
               scl_lvl = 1'b1;
               sda_lvl = 1'b1;
            end else if (st == 3'd1) sda_lvl = 1'b0;
            else scl_lvl = 1'b0;
         end
         PH_SBIT: begin
            if (st == 3'd0) begin
               scl_lvl = 1'b0;
               sda_lvl = shifter[3'd7 - bit_pos];
            end else scl_lvl = 1'b1;
         end
         PH_SACK: begin
            if (st == 3'd0) scl_lvl = 1'b0;
            else if (st == 3'd1) sda_lvl = 1'b1;
            else scl_lvl = 1'b1;
         end
         PH_GAP: if (st == 3'd1) scl_lvl = 1'b0;
         PH_RBIT: begin
            if (st == 3'd0) begin
               if (bit_pos == 3'd0) sda_lvl = 1'b1;
               scl_lvl = 1'b0;
            end else begin
               // A read bit is taken on the tick that SCL rises.
               scl_lvl = 1'b1;
               shifter = {shifter[6:0], sda_sample};
               if (bit_pos == 3'd7) begin
                  got_valid = 1'b1;
                  got_byte = shifter;
               end
            end
         end
         PH_RTAIL: scl_lvl = 1'b0;
         PH_MACK: begin
            if (st == 3'd0) sda_lvl = 1'b0;
            else if (st == 3'd1) scl_lvl = 1'b1;
            else scl_lvl = 1'b0;
         end
         PH_NACK: begin
            if (st == 3'd0) sda_lvl = 1'b1;
            else if (st == 3'd1) scl_lvl = 1'b1;
            else scl_lvl = 1'b0;
         end
         PH_STOP: begin
            if (st == 3'd0) scl_lvl = 1'b0;
            else if (st == 3'd1) sda_lvl = 1'b0;
            else if (st == 3'd2) scl_lvl = 1'b1;
            else sda_lvl = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic void shift_out(input logic [7:0] value);
      shifter = value;
      bit_pos = '0;
      enter_slot(PH_SBIT, 3'd0);
   endfunction

   function automatic void next_payload();
      logic [7:0] value;
      if (bytes_to_go != 5'd0) begin
         value = (tx_ptr < BUF_DEPTH) ? tx_buffer[tx_ptr[3:0]] : 8'h00;
         tx_ptr++;
         bytes_to_go--;
         xfer_stage = ST_DATA;
         shift_out(value);
      end else enter_slot(PH_STOP, 3'd0);
   endfunction

   function automatic void after_byte();
      case (xfer_stage)
         ST_DEV: begin
            xfer_stage = ST_REG;
            shift_out(reg_addr);
         end
         ST_REG: begin
            if (is_read) enter_slot(PH_GAP, 3'd0);
            else next_payload();
         end
         ST_DATA: next_payload();
         default: begin
            shifter = '0;
            bit_pos = '0;
            enter_slot(PH_RBIT, 3'd0);
         end
      endcase
   endfunction

   function automatic void advance_slot();
      case (bus_phase)
         PH_START: begin
            if (slot_idx < 3'd2) enter_slot(PH_START, slot_idx + 3'd1);
            else if (xfer_stage == ST_RDEV) shift_out(dev_addr + 8'd1);
            else shift_out(dev_addr);
         end
         PH_SBIT: begin
            if (slot_idx == 3'd0) enter_slot(PH_SBIT, 3'd1);
            else if (bit_pos < 3'd7) begin
               bit_pos++;
               enter_slot(PH_SBIT, 3'd0);
            end else enter_slot(PH_SACK, 3'd0);
         end
         PH_SACK: begin
            // The slave's ack is taken on the last tick of the ack slot; a nack never aborts.
            if (slot_idx < 3'd2) enter_slot(PH_SACK, slot_idx + 3'd1);
            else begin
               slave_ack = ~sda_sample;
               after_byte();
            end
         end
         PH_GAP: begin
            if (slot_idx < 3'd2) enter_slot(PH_GAP, slot_idx + 3'd1);
            else begin
               xfer_stage = ST_RDEV;
               enter_slot(PH_START, 3'd0);
            end
         end
         PH_RBIT: begin
            if (slot_idx == 3'd0) enter_slot(PH_RBIT, 3'd1);
            else if (bit_pos < 3'd7) begin
               bit_pos++;
               enter_slot(PH_RBIT, 3'd0);
            end else enter_slot(PH_RTAIL, 3'd0);
         end
         PH_RTAIL: begin
            if (bytes_to_go != 5'd0) bytes_to_go--;
            if (bytes_to_go != 5'd0) enter_slot(PH_MACK, 3'd0);
            else enter_slot(PH_NACK, 3'd0);
         end
         PH_MACK: begin
            if (slot_idx < 3'd2) enter_slot(PH_MACK, slot_idx + 3'd1);
            else begin
               sda_lvl = 1'b1;
               shifter = '0;
               bit_pos = '0;
               enter_slot(PH_RBIT, 3'd0);
            end
         end
         PH_NACK: begin
            if (slot_idx < 3'd2) enter_slot(PH_NACK, slot_idx + 3'd1);
            else enter_slot(PH_STOP, 3'd0);
         end
         PH_STOP: begin
            if (slot_idx < 3'd3) enter_slot(PH_STOP, slot_idx + 3'd1);
            else begin
               bus_phase = PH_IDLE;
               slot_idx = '0;
               got_done = 1'b1;
            end
         end
         default: bus_phase = PH_IDLE;
      endcase
   endfunction

   function automatic step_out_type predict_step(input step_in_type req);
      step_out_type result;
      logic [15:0] slot_len;
      slot_len = (slot_cfg == 16'd0) ? 16'd1 : slot_cfg;
      sda_sample = req.sda_in;
      got_valid = 1'b0;
      got_byte = '0;
      got_done = 1'b0;
      if (bus_phase != PH_IDLE) begin
         // While a transfer runs every item is a plain tick, whatever its action.
         tick_count = tick_count + 16'd1;
         if (tick_count >= slot_len) begin
            tick_count = '0;
            advance_slot();
         end
      end else if (req.action == ACT_WRITE || req.action == ACT_READ) begin
         dev_addr = req.device_address;
         reg_addr = req.register_address;
         is_read = (req.action == ACT_READ);
         if (is_read) bytes_to_go = (req.byte_count == 5'd0) ? 5'd1 : req.byte_count;
         else begin
            bytes_to_go = (req.byte_count > BUF_DEPTH) ? 5'(BUF_DEPTH) : req.byte_count;
            tx_fill = '0;
         end
         tx_ptr = '0;
         xfer_stage = ST_DEV;
         bit_pos = '0;
         tick_count = '0;
         transfers_begun++;
         enter_slot(PH_START, 3'd0);
      end else if (req.action == ACT_LOAD) begin
         if (tx_fill < BUF_DEPTH) begin
            tx_buffer[tx_fill[3:0]] = req.write_data;
            tx_fill++;
         end
      end
      result.scl_out = scl_lvl;
      result.sda_out = sda_lvl;
      result.read_data = got_byte;
      result.read_valid = got_valid;
      result.ack_received = slave_ack;
      result.busy_res = (bus_phase != PH_IDLE);
      result.done_res = got_done;
      return result;
   endfunction

   function automatic int unsigned mood_percent();
      case ($urandom_range(2))
         0: return 0;
         1: return 6;
         default: return 30;
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [4:0] rand_count();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 75) return 5'($urandom_range(3));
      else if (p < 96) return 5'($urandom_range(16, 4));
      else return 5'($urandom_range(31, 17));
   endfunction

   function automatic logic line_level();
      if (sda_mode == 0) return 1'b0;
      else if (sda_mode == 1) return 1'b1;
      else return 1'($urandom_range(1));
   endfunction

   task automatic report(input string what, input int unsigned want, input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("MISMATCH at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
   endtask

   task automatic send_item(input action_type act, input logic [7:0] dev, input logic [7:0] regad,
                            input logic [7:0] data, input logic [4:0] count, input logic sda);
      step_in_type req;
      req.action = act;
      req.device_address = dev;
      req.register_address = regad;
      req.write_data = data;
      req.byte_count = count;
      req.sda_in = sda;
      if (items_sent % 64 == 0) gap_percent = mood_percent();
      if (!calm && $urandom_range(99) < gap_percent) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(16)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.action <= req.action;
      req_ch.device_address <= req.device_address;
      req_ch.register_address <= req.register_address;
      req_ch.write_data <= req.write_data;
      req_ch.byte_count <= req.byte_count;
      req_ch.sda_in <= req.sda_in;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_steps.push_back(predict_step(req));
      items_sent++;
   endtask

   task automatic finish_transfer();
      while (bus_phase != PH_IDLE)
         send_item(action_type'($urandom_range(3)), rand_byte(), rand_byte(), rand_byte(),
                   5'($urandom_range(31)), line_level());
   endtask

   task automatic set_slot_ticks(input logic [15:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      slot_cfg = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_item(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 5'h1F, 1'b1);
      send_item(ACT_TICK, 8'h00, 8'h00, 8'h00, 5'h00, 1'b0);
      // A zero-length write at the reset slot length, with every ack answered as a nack.
      sda_mode = 1;
      send_item(ACT_WRITE, 8'hA0, 8'h10, 8'h00, 5'd0, 1'b1);
      finish_transfer();
   endtask

   task automatic test_buffer_fill();
      logic [7:0] data;
      // Seventeen loads: the last one finds the buffer full and is dropped.
      for (int i = 0; i < BUF_DEPTH + 1; i++) begin
         data = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'h80 : (i == 3) ? 8'h01
                : rand_byte();
         send_item(ACT_LOAD, rand_byte(), rand_byte(), data, 5'($urandom_range(31)),
                   1'($urandom_range(1)));
      end
   endtask

   task automatic test_write_transfers();
      set_slot_ticks(16'd1);
      sda_mode = 2;
      send_item(ACT_WRITE, 8'hFF, 8'h00, rand_byte(), 5'd31, 1'b0);
      finish_transfer();
      send_item(ACT_LOAD, 8'h00, 8'h00, 8'hA5, 5'd0, 1'b0);
      send_item(ACT_LOAD, 8'hFF, 8'hFF, 8'h3C, 5'd31, 1'b1);
      // Three bytes from two fresh loads: the last comes from an entry left by earlier loads.
      sda_mode = 0;
      send_item(ACT_WRITE, 8'h00, 8'hFF, rand_byte(), 5'd3, 1'b1);
      finish_transfer();
   endtask

   task automatic test_read_transfers();
      sda_mode = 2;
      send_item(ACT_READ, 8'h42, 8'h7F, rand_byte(), 5'd3, 1'b1);
      finish_transfer();
   endtask

   task automatic test_slot_lengths();
      // A read count of zero still fetches one byte; device 0xFF wraps to 0x00 for the read.
      set_slot_ticks(16'd0);
      sda_mode = 1;
      send_item(ACT_READ, 8'hFF, 8'h55, rand_byte(), 5'd0, 1'b1);
      finish_transfer();
      // At the longest slot a transfer would run past the bench's cycle limit, so only idle work here.
      set_slot_ticks(16'hFFFF);
      send_item(ACT_TICK, rand_byte(), rand_byte(), rand_byte(), 5'd0, 1'b1);
      send_item(ACT_LOAD, rand_byte(), rand_byte(), rand_byte(), 5'd16, 1'b0);
      send_item(ACT_TICK, rand_byte(), rand_byte(), rand_byte(), 5'd31, 1'b0);
   endtask

   task automatic test_random_traffic(input logic [15:0] slot, input int unsigned quota);
      int unsigned stop_at;
      int unsigned pick;
      set_slot_ticks(slot);
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         sda_mode = $urandom_range(4);
         if (pick < 12)
            send_item(ACT_TICK, rand_byte(), rand_byte(), rand_byte(), rand_count(),
                      1'($urandom_range(1)));
         else if (pick < 55) begin
            repeat (($urandom_range(9) == 0) ? $urandom_range(17) : $urandom_range(3))
               send_item(ACT_LOAD, rand_byte(), rand_byte(), rand_byte(), rand_count(),
                         1'($urandom_range(1)));
            send_item(ACT_WRITE, rand_byte(), rand_byte(), rand_byte(), rand_count(),
                      1'($urandom_range(1)));
            finish_transfer();
         end else begin
            send_item(ACT_READ, rand_byte(), rand_byte(), rand_byte(), rand_count(),
                      1'($urandom_range(1)));
            finish_transfer();
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      step_out_type seen;
      step_out_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.scl_out = rsp_ch.scl_out;
         seen.sda_out = rsp_ch.sda_out;
         seen.read_data = rsp_ch.read_data;
         seen.read_valid = rsp_ch.read_valid;
         seen.ack_received = rsp_ch.ack_received;
         seen.busy_res = rsp_ch.busy_res;
         seen.done_res = rsp_ch.done_res;
         if (expected_steps.size() == 0) report("result with nothing expected", 0, seen);
         else begin
            want = expected_steps.pop_front();
            if (seen.scl_out !== want.scl_out) report("scl_out", want.scl_out, seen.scl_out);
            if (seen.sda_out !== want.sda_out) report("sda_out", want.sda_out, seen.sda_out);
            if (seen.read_data !== want.read_data)
               report("read_data", want.read_data, seen.read_data);
            if (seen.read_valid !== want.read_valid)
               report("read_valid", want.read_valid, seen.read_valid);
            if (seen.ack_received !== want.ack_received)
               report("ack_received", want.ack_received, seen.ack_received);
            if (seen.busy_res !== want.busy_res) report("busy_res", want.busy_res, seen.busy_res);
            if (seen.done_res !== want.done_res) report("done_res", want.done_res, seen.done_res);
            if (want.read_valid) bytes_read++;
            if (want.done_res) transfers_done++;
         end
      end
   end

   // Result side back-pressure in bursts, with quiet stretches in between.
   always @(negedge clock) begin
      drain_cycles++;
      if (drain_cycles % 151 == 0) stall_percent = mood_percent();
      if (!reset && !calm && $urandom_range(99) < stall_percent) begin
         rsp_ch.ready <= 1'b0;
         repeat ($urandom_range(16)) @(negedge clock);
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_TICK;
      req_ch.device_address = '0;
      req_ch.register_address = '0;
      req_ch.write_data = '0;
      req_ch.byte_count = '0;
      req_ch.sda_in = 1'b1;
      rsp_ch.ready = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_buffer_fill();
      test_write_transfers();
      test_read_transfers();
      test_slot_lengths();
      test_random_traffic(16'($urandom_range(2, 1)), 60);
      calm = 1'b1;
      test_random_traffic(16'd1, 20);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      for (int w = 0; w < 1000 && expected_steps.size() != 0; w++) @(posedge clock);
      if (expected_steps.size() != 0)
         report("results never delivered", expected_steps.size(), 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d items covering %0d transfers at slot lengths from 0 to 65535.",
               items_sent, transfers_begun);
      $display("%0d transfers reached their stop condition and %0d bytes were read back.",
               transfers_done, bytes_read);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

// ===== i2c_master_register_access.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_ram.sv
rtl/i2cm_seq.sv
rtl/i2c_master_register_access.sv
rtl/i2cm_checker.sv
bench/testbench.sv
